// ===== src/pec_pkg.sv =====
// ----------------------------------------------------------------------------
// pec_pkg: shared definitions for the percent-escape codec
// Character constants, decode phase codes and the character class helpers.
// ----------------------------------------------------------------------------
package pec_pkg;

    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;

    // Marks a hex value lookup that found no uppercase hex digit.
    localparam logic [4:0] HEX_NONE   = 5'd16;

    // Remaining digit beats of an escape that is being emitted.
    localparam logic [1:0] ESC_NONE   = 2'd0;
    localparam logic [1:0] ESC_LOW    = 2'd1;
    localparam logic [1:0] ESC_HIGH   = 2'd2;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_PCT   = 3'b010,
        PH_HEX   = 3'b100
    } phase_t;

    function automatic logic is_plain(input logic [7:0] c);
        return (c >= CHAR_A && c <= CHAR_Z) || (c >= CHAR_LA && c <= CHAR_LZ) ||
               (c >= CHAR_0 && c <= CHAR_9) || c == CHAR_DASH || c == CHAR_UNDER;
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            d = c - CHAR_0;
            return d[4:0];
        end
        if (c >= CHAR_A && c <= CHAR_F)
        begin
            d = c - CHAR_A + 8'd10;
            return d[4:0];
        end
        return HEX_NONE;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
            return CHAR_0 + {4'b0000, n};
        return CHAR_A - 8'd10 + {4'b0000, n};
    endfunction

endpackage

// ===== src/percent_escape_codec.sv =====
// ----------------------------------------------------------------------------
// percent_escape_codec: streaming percent-escape encoder and decoder
// One byte of a string per input beat; direction register selects the mode.
// ----------------------------------------------------------------------------
// A decode byte is taken every cycle while the output register is free and
// gives one result beat in the next cycle. An encode byte that passes through
// does the same; a byte that is escaped gives three result beats ('%' and two
// hex digits) from one output register, so the input stalls for the two digit
// beats. The output register is refilled in the cycle it is taken, so a
// waiting result never blocks the next input by itself. Direction writes are
// taken at once and clear the decode state; they belong between strings.
module percent_escape_codec
    import pec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       has_data,
    output logic       status,
    output logic       last_of_run,
    output logic       string_done,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       direction
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg,  out_byte_next;
    logic       has_data_reg,  has_data_next;
    logic       status_reg,    status_next;
    logic       last_reg,      last_next;
    logic       done_reg,      done_next;
    logic [1:0] esc_cnt_reg,   esc_cnt_next;
    logic [7:0] esc_byte_reg,  esc_byte_next;
    logic       esc_eos_reg,   esc_eos_next;
    logic       dir_reg,       dir_next;
    phase_t     phase_reg,     phase_next;
    logic [3:0] nib_reg,       nib_next;
    logic       err_reg,       err_next;

    logic       out_free;
    logic       in_accept;
    logic       cfg_write;
    logic [4:0] hval;
    logic       dec_has;
    logic [7:0] dec_byte;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !out_free || (esc_cnt_reg != ESC_NONE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign has_data    = has_data_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;
    assign string_done = done_reg;

    assign hval = hex_value(in_byte);

    // Decode step for the byte on the input, against the current phase.
    always_comb
    begin
        phase_next = phase_reg;
        nib_next   = nib_reg;
        err_next   = err_reg;
        dec_has    = 1'b0;
        dec_byte   = 8'd0;
        if (!err_reg)
        begin
            unique case (phase_reg)
                PH_PLAIN:
                begin
                    if (in_byte == CHAR_PCT)
                        phase_next = PH_PCT;
                    else if (is_plain(in_byte))
                    begin
                        dec_has  = 1'b1;
                        dec_byte = in_byte;
                    end
                    else
                        err_next = 1'b1;
                end
                PH_PCT:
                begin
                    if (!hval[4])
                    begin
                        nib_next   = hval[3:0];
                        phase_next = PH_HEX;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_PLAIN;
                    end
                end
                PH_HEX:
                begin
                    if (!hval[4])
                    begin
                        dec_has  = 1'b1;
                        dec_byte = {nib_reg, hval[3:0]};
                    end
                    else
                        err_next = 1'b1;
                    phase_next = PH_PLAIN;
                    nib_next   = 4'd0;
                end
                default:
                begin
                    phase_next = PH_PLAIN;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        has_data_next  = has_data_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        esc_cnt_next   = esc_cnt_reg;
        esc_byte_next  = esc_byte_reg;
        esc_eos_next   = esc_eos_reg;
        if (out_free)
        begin
            if (esc_cnt_reg == ESC_HIGH)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = hex_digit(esc_byte_reg[7:4]);
                has_data_next  = 1'b1;
                status_next    = 1'b0;
                last_next      = 1'b0;
                done_next      = 1'b0;
                esc_cnt_next   = ESC_LOW;
            end
            else if (esc_cnt_reg == ESC_LOW)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = hex_digit(esc_byte_reg[3:0]);
                has_data_next  = 1'b1;
                status_next    = 1'b0;
                last_next      = 1'b1;
                done_next      = esc_eos_reg;
                esc_cnt_next   = ESC_NONE;
            end
            else if (in_accept)
            begin
                out_valid_next = 1'b1;
                if (!dir_reg)
                begin
                    has_data_next = 1'b1;
                    status_next   = 1'b0;
                    if (is_plain(in_byte))
                    begin
                        out_byte_next = in_byte;
                        last_next     = 1'b1;
                        done_next     = end_of_string;
                    end
                    else
                    begin
                        // The two hex digits follow from the escape registers.
                        out_byte_next = CHAR_PCT;
                        last_next     = 1'b0;
                        done_next     = 1'b0;
                        esc_cnt_next  = ESC_HIGH;
                        esc_byte_next = in_byte;
                        esc_eos_next  = end_of_string;
                    end
                end
                else
                begin
                    out_byte_next = dec_byte;
                    has_data_next = dec_has;
                    status_next   = err_next;
                    last_next     = 1'b1;
                    done_next     = end_of_string;
                end
            end
            else
                out_valid_next = 1'b0;
        end
    end

    assign dir_next = cfg_write ? direction : dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            esc_cnt_reg   <= ESC_NONE;
            dir_reg       <= 1'b0;
            phase_reg     <= PH_PLAIN;
            nib_reg       <= 4'd0;
            err_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            esc_cnt_reg   <= esc_cnt_next;
            dir_reg       <= dir_next;
            if (cfg_write || (in_accept && dir_reg && end_of_string))
            begin
                phase_reg <= PH_PLAIN;
                nib_reg   <= 4'd0;
                err_reg   <= 1'b0;
            end
            else if (in_accept && dir_reg)
            begin
                phase_reg <= phase_next;
                nib_reg   <= nib_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        has_data_reg <= has_data_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
        done_reg     <= done_next;
        esc_byte_reg <= esc_byte_next;
        esc_eos_reg  <= esc_eos_next;
    end

endmodule

// ===== src/pec_checker.sv =====
// ----------------------------------------------------------------------------
// pec_checker: port-level checks for the percent-escape codec
// Watches the result channel and the input stall over time.
// ----------------------------------------------------------------------------
module pec_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       has_data,
    input logic       last_of_run,
    input logic       string_done
);

    // A stalled result beat stays and keeps its byte.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte))
        else $error("stalled result beat changed");

    // While an escape is still being emitted no new input beat is taken.
    a_run_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> in_stall)
        else $error("input taken inside an escape run");

    // The end of a string only comes with the last beat of a run.
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_done |-> last_of_run)
        else $error("string end on a non-final beat");

    // A beat without data carries a zero byte.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_data |-> out_byte == 8'd0)
        else $error("empty beat carries a byte");

endmodule

bind percent_escape_codec pec_checker u_pec_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .has_data    (has_data),
    .last_of_run (last_of_run),
    .string_done (string_done)
);
